// ----- design/bcdc_pkg.sv -----
`timescale 1ns / 1ps

package bcdc_pkg;

  // Request types
  localparam logic [1:0] REQ_KEY  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  // Key codes
  localparam logic [3:0] KEY_EDIT      = 4'd1;
  localparam logic [3:0] KEY_NEXT      = 4'd2;
  localparam logic [3:0] KEY_ADD       = 4'd3;
  localparam logic [3:0] KEY_SUB       = 4'd4;
  localparam logic [3:0] KEY_STORE     = 4'd5;
  localparam logic [3:0] KEY_ALM_SET   = 4'd6;
  localparam logic [3:0] KEY_ALM_TOG   = 4'd7;
  localparam logic [3:0] KEY_ALM_UP    = 4'd8;
  localparam logic [3:0] KEY_ALM_DOWN  = 4'd9;

  // Configuration register indexes
  localparam logic CFG_BLINK_PERIOD = 1'b0;
  localparam logic CFG_TONE_SEGMENT = 1'b1;

  localparam logic [15:0] BLINK_PERIOD_RST = 16'd1000;
  localparam logic [15:0] TONE_SEGMENT_RST = 16'd250;

  localparam logic [4:0] ALARM_HOUR_MAX   = 5'd23;
  localparam logic [5:0] ALARM_MINUTE_MAX = 6'd59;

  // edit items
  localparam logic [2:0] EDIT_YEAR        = 3'd0;
  localparam logic [2:0] EDIT_MONTH       = 3'd1;
  localparam logic [2:0] EDIT_DAY         = 3'd2;
  localparam logic [2:0] EDIT_HOUR        = 3'd3;
  localparam logic [2:0] EDIT_LAST        = 3'd5;

  // time field slots: 0 sec, 1 min, 2 hour, 3 day, 4 month, 5 year
  localparam logic [2:0] SLOT_MINUTE = 3'd1;
  localparam logic [2:0] SLOT_HOUR   = 3'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_code;
    logic [7:0] load_second;
    logic [7:0] load_minute;
    logic [7:0] load_hour;
    logic [7:0] load_day;
    logic [7:0] load_month;
    logic [7:0] load_year;
  } req_t;

  typedef struct packed {
    logic [7:0] out_second;
    logic [7:0] out_minute;
    logic [7:0] out_hour;
    logic [7:0] out_day;
    logic [7:0] out_month;
    logic [7:0] out_year;
    logic [2:0] edit_field;
    logic [4:0] alarm_hour_out;
    logic [5:0] alarm_minute_out;
    logic [5:0] mode_flags;
    logic       buzzer_level;
    logic       write_back;
  } rsp_t;

  typedef struct packed {
    logic [5:0][7:0] tf;
    logic            edit_on;
    logic [2:0]      edit_sel;
    logic            alm_edit_on;
    logic            alarm_item;
    logic            alm_armed;
    logic [4:0]      alm_hr;
    logic [5:0]      alm_min;
    logic            ringing;
    logic            stopped;
    logic [15:0]     blink_count;
    logic            blink;
    logic [15:0]     tone_count;
    logic            tone_phase;
    logic            buzzer;
  } state_t;

  localparam state_t STATE_RST = '{
    tf: '0, edit_on: 1'b0, edit_sel: 3'd0, alm_edit_on: 1'b0,
    alarm_item: 1'b0, alm_armed: 1'b0, alm_hr: 5'd0,
    alm_min: 6'd0, ringing: 1'b0, stopped: 1'b1, blink_count: 16'd0,
    blink: 1'b0, tone_count: 16'd0, tone_phase: 1'b0, buzzer: 1'b1
  };

  // raw nibbles, tens*10 + units; up to 165 for bad digits
  function automatic logic [7:0] bcd_decode(input logic [7:0] v);
    logic [7:0] t;
    t = {4'd0, v[7:4]};
    return (t << 3) + (t << 1) + {4'd0, v[3:0]};
  endfunction

  // value must be 0..99; quotient by reciprocal multiply
  function automatic logic [7:0] bcd_encode(input logic [7:0] b);
    logic [15:0] p;
    logic [3:0]  q;
    logic [7:0]  r;
    p = {8'd0, b} * 16'd205;
    q = p[14:11];
    r = b - (({4'd0, q} << 3) + ({4'd0, q} << 1));
    return {q, r[3:0]};
  endfunction

  // limits by edit item: 0 year, 1 month, 2 day, 3 hour, 4 minute, 5 second
  function automatic logic [7:0] fld_min(input logic [2:0] it);
    case (it) inside
      EDIT_MONTH, EDIT_DAY: return 8'd1;
      default:              return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] fld_max(input logic [2:0] it);
    case (it)
      EDIT_YEAR:  return 8'd99;
      EDIT_MONTH: return 8'd12;
      EDIT_DAY:   return 8'd31;
      EDIT_HOUR:  return 8'd23;
      default:    return 8'd59;
    endcase
  endfunction

endpackage

// ----- design/bcdc_update.sv -----
`timescale 1ns / 1ps

module bcdc_update (
  input  bcdc_pkg::state_t st,
  input  bcdc_pkg::req_t   req,
  input  logic [15:0]      blink_period,
  input  logic [15:0]      tone_segment,
  output bcdc_pkg::state_t st_nxt,
  output bcdc_pkg::rsp_t   rsp
);

  logic [2:0]  slot;
  logic [7:0]  fb;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [7:0]  up_val;
  logic [7:0]  dn_val;
  logic [7:0]  step_enc;
  logic [15:0] bc;
  logic [15:0] tc;
  logic        wb;
  bcdc_pkg::state_t n;

  // selected field and its stepped value
  always_comb begin
    slot     = bcdc_pkg::EDIT_LAST - st.edit_sel;
    fb       = bcdc_pkg::bcd_decode(st.tf[slot]);
    lo       = bcdc_pkg::fld_min(st.edit_sel);
    hi       = bcdc_pkg::fld_max(st.edit_sel);
    up_val   = (fb >= hi) ? lo : fb + 8'd1;
    dn_val   = (fb <= lo || fb > hi) ? hi : fb - 8'd1;
    step_enc = bcdc_pkg::bcd_encode((req.key_code == bcdc_pkg::KEY_ADD) ? up_val : dn_val);
  end

  always_comb begin
    n  = st;
    wb = 1'b0;
    bc = st.blink_count + 16'd1;
    tc = st.tone_count + 16'd1;
    unique case (req.req_type)
      bcdc_pkg::REQ_KEY: begin
        if (req.key_code == bcdc_pkg::KEY_EDIT) begin
          n.edit_on  = ~st.edit_on;
          n.edit_sel = 3'd0;
        end
        if (n.edit_on) begin
          case (req.key_code) inside
            bcdc_pkg::KEY_NEXT:
              n.edit_sel = (st.edit_sel >= bcdc_pkg::EDIT_LAST) ? 3'd0 : st.edit_sel + 3'd1;
            bcdc_pkg::KEY_ADD, bcdc_pkg::KEY_SUB: n.tf[slot] = step_enc;
            bcdc_pkg::KEY_STORE: begin
              n.edit_on = 1'b0;
              wb        = 1'b1;
            end
            default: ;
          endcase
        end
        if (req.key_code == bcdc_pkg::KEY_ALM_SET) begin
          n.alm_edit_on = ~st.alm_edit_on;
          if (n.alm_edit_on) n.alarm_item = 1'b0;
        end
        if (req.key_code == bcdc_pkg::KEY_ALM_TOG) begin
          if (st.ringing) begin
            n.ringing = 1'b0;
            n.stopped = 1'b1;
            n.buzzer  = 1'b1;
          end else begin
            n.alm_armed = ~st.alm_armed;
            n.stopped   = 1'b0;
          end
        end
        if (n.alm_edit_on) begin
          case (req.key_code)
            bcdc_pkg::KEY_NEXT: n.alarm_item = ~st.alarm_item;
            bcdc_pkg::KEY_ALM_UP: begin
              if (!st.alarm_item)
                n.alm_hr = (st.alm_hr >= bcdc_pkg::ALARM_HOUR_MAX) ? 5'd0
                         : st.alm_hr + 5'd1;
              else
                n.alm_min = (st.alm_min >= bcdc_pkg::ALARM_MINUTE_MAX) ? 6'd0
                          : st.alm_min + 6'd1;
            end
            bcdc_pkg::KEY_ALM_DOWN: begin
              if (!st.alarm_item)
                n.alm_hr = (st.alm_hr == 5'd0 ||
                            st.alm_hr > bcdc_pkg::ALARM_HOUR_MAX)
                         ? bcdc_pkg::ALARM_HOUR_MAX : st.alm_hr - 5'd1;
              else
                n.alm_min = (st.alm_min == 6'd0 ||
                             st.alm_min > bcdc_pkg::ALARM_MINUTE_MAX)
                          ? bcdc_pkg::ALARM_MINUTE_MAX : st.alm_min - 6'd1;
            end
            default: ;
          endcase
        end
      end
      bcdc_pkg::REQ_TICK: begin
        if (bc >= blink_period) begin
          n.blink_count = 16'd0;
          n.blink       = ~st.blink;
        end else begin
          n.blink_count = bc;
        end
        if (st.ringing) begin
          if (tc >= tone_segment) begin
            n.tone_count = 16'd0;
            n.tone_phase = ~st.tone_phase;
          end else begin
            n.tone_count = tc;
          end
          // phase 0: half-rate toggle, phase 1: full-rate toggle
          if (n.tone_phase || !n.tone_count[0]) n.buzzer = ~st.buzzer;
        end else begin
          n.buzzer = 1'b1;
        end
      end
      bcdc_pkg::REQ_LOAD: begin
        if (!st.edit_on) begin
          n.tf[0] = req.load_second;
          n.tf[1] = req.load_minute;
          n.tf[2] = req.load_hour;
          n.tf[3] = req.load_day;
          n.tf[4] = req.load_month;
          n.tf[5] = req.load_year;
        end
      end
      default: ;
    endcase

    // alarm match on the updated time
    if (n.alm_armed && !n.stopped && !n.ringing &&
        bcdc_pkg::bcd_decode(n.tf[bcdc_pkg::SLOT_HOUR]) == {3'd0, n.alm_hr} &&
        bcdc_pkg::bcd_decode(n.tf[bcdc_pkg::SLOT_MINUTE]) == {2'd0, n.alm_min}) begin
      n.ringing    = 1'b1;
      n.tone_count = 16'd0;
      n.tone_phase = 1'b0;
    end
  end

  assign st_nxt = n;

  always_comb begin
    rsp.out_second       = n.tf[0];
    rsp.out_minute       = n.tf[1];
    rsp.out_hour         = n.tf[2];
    rsp.out_day          = n.tf[3];
    rsp.out_month        = n.tf[4];
    rsp.out_year         = n.tf[5];
    rsp.edit_field       = n.edit_sel;
    rsp.alarm_hour_out   = n.alm_hr;
    rsp.alarm_minute_out = n.alm_min;
    rsp.mode_flags       = {n.blink, n.ringing, n.alm_armed, n.alarm_item,
                            n.alm_edit_on, n.edit_on};
    rsp.buzzer_level     = n.buzzer;
    rsp.write_back       = wb;
  end

endmodule

// ----- design/bcd_clock_setter_with_alarm.sv -----
`timescale 1ns / 1ps

// Alarm clock controller with BCD time setting.
//
// Input channel (in_valid/in_ready/in_data): one request per transfer, a key
// event, a millisecond tick or a time load from the clock chip.
// Result channel (out_valid/out_ready/out_data): exactly one result per
// request: the six BCD time fields, edit item, alarm time, mode flags,
// buzzer level and a one-shot write_back on save.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// blink period, index 1 the tone segment length, both in ticks. Always ready;
// write only while no request is in flight.
//
// The request is registered, then the state update and result are computed
// in one pass and registered: a request passes the input register and then
// the result register. While the receiver keeps taking results, throughput
// is one request per cycle, set by that single state-update pass.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are occupied.
// Reset (rst_n low, synchronous) clears the time to zero, the alarm to
// 00:00 disabled, the buzzer silent, and the registers to 1000 and 250.

module bcd_clock_setter_with_alarm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bcdc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bcdc_pkg::rsp_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data
);

  logic             stg_valid_r, stg_valid_nxt;
  bcdc_pkg::req_t   stg_data_r;
  logic             out_valid_r, out_valid_nxt;
  bcdc_pkg::rsp_t   out_data_r;
  bcdc_pkg::state_t st_r, st_nxt;
  bcdc_pkg::rsp_t   rsp;
  logic [15:0]      blink_period_r;
  logic [15:0]      tone_segment_r;
  logic             proc_go;

  // the staged request is processed when the result register is free or
  // being emptied this cycle
  assign proc_go   = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || proc_go;
  assign cfg_ready = 1'b1;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_valid && in_ready) stg_valid_nxt = 1'b1;
    else if (proc_go)         stg_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (proc_go)        out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  bcdc_update u_update (
    .st           (st_r),
    .req          (stg_data_r),
    .blink_period (blink_period_r),
    .tone_segment (tone_segment_r),
    .st_nxt       (st_nxt),
    .rsp          (rsp)
  );

  // control and clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      st_r           <= bcdc_pkg::STATE_RST;
      blink_period_r <= bcdc_pkg::BLINK_PERIOD_RST;
      tone_segment_r <= bcdc_pkg::TONE_SEGMENT_RST;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (proc_go) st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bcdc_pkg::CFG_BLINK_PERIOD: blink_period_r <= cfg_data;
          bcdc_pkg::CFG_TONE_SEGMENT: tone_segment_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stg_data_r <= in_data;
    if (proc_go)              out_data_r <= rsp;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // buzzer is only driven while ringing; otherwise it sits silent
  a_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mode_flags[4] |-> out_data.buzzer_level)
    else $error("buzzer active while not ringing");

  // save leaves set mode in the same result
  a_save_exits_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_back |-> !out_data.mode_flags[0])
    else $error("write_back with set mode still on");

  // alarm time and edit item stay in range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.alarm_hour_out <= bcdc_pkg::ALARM_HOUR_MAX) &&
                  (out_data.alarm_minute_out <= bcdc_pkg::ALARM_MINUTE_MAX) &&
                  (out_data.edit_field <= bcdc_pkg::EDIT_LAST))
    else $error("alarm time or edit item out of range");

  // a processed request always leaves a result pending next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go |=> out_valid)
    else $error("processed request produced no result");

endmodule

// ----- verif/bcd_clock_setter_with_alarm_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and register channels of the alarm clock block,
// keeps its own copy of the clock state, and checks every result in order.
module bcd_clock_setter_with_alarm_checker
  import bcdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  rsp_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          expected_left
);

  // time slots not named in the package
  localparam int SLOT_SEC   = 0;
  localparam int SLOT_DAY   = 3;
  localparam int SLOT_MONTH = 4;
  localparam int SLOT_YEAR  = 5;

  logic [15:0] blink_len, tone_len;
  logic [7:0]  time_bcd [6];
  logic        editing, alarm_editing, alarm_edit_min, alarm_armed;
  logic [2:0]  edit_item;
  logic [4:0]  alm_hour;
  logic [5:0]  alm_minute;
  logic        ringing_now, silenced, blink_lvl, tone_half, buzzer_pin;
  logic [15:0] blink_ticks, tone_ticks;

  rsp_t display_q [$];
  rsp_t want;

  initial begin
    fail_count    = 0;
    expected_left = 0;
  end

  function automatic int bcd_value(logic [7:0] v);
    return int'(v[7:4]) * 10 + int'(v[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(int b);
    return {4'(b / 10), 4'(b % 10)};
  endfunction

  task automatic clear_model();
    blink_len      = BLINK_PERIOD_RST;
    tone_len       = TONE_SEGMENT_RST;
    foreach (time_bcd[i]) time_bcd[i] = 8'h00;
    editing        = 1'b0;
    edit_item      = EDIT_YEAR;
    alarm_editing  = 1'b0;
    alarm_edit_min = 1'b0;
    alarm_armed    = 1'b0;
    alm_hour       = 5'd0;
    alm_minute     = 6'd0;
    ringing_now    = 1'b0;
    silenced       = 1'b1;
    blink_ticks    = 16'd0;
    blink_lvl      = 1'b0;
    tone_ticks     = 16'd0;
    tone_half      = 1'b0;
    buzzer_pin     = 1'b1;
  endtask

  // wrapping step of the selected time field; bad digits decode raw
  function automatic void step_time(logic up);
    int slot, lo, hi, b;
    slot = 5 - int'(edit_item);
    lo   = (edit_item == EDIT_MONTH || edit_item == EDIT_DAY) ? 1 : 0;
    case (edit_item)
      EDIT_YEAR:  hi = 99;
      EDIT_MONTH: hi = 12;
      EDIT_DAY:   hi = 31;
      EDIT_HOUR:  hi = 23;
      default:    hi = 59;
    endcase
    b = bcd_value(time_bcd[slot]);
    if (up) b = (b >= hi) ? lo : b + 1;
    else    b = (b <= lo || b > hi) ? hi : b - 1;
    time_bcd[slot] = to_bcd(b);
  endfunction

  function automatic rsp_t next_display(req_t r);
    rsp_t res;
    logic saved;
    saved = 1'b0;
    case (r.req_type)
      REQ_KEY: begin
        if (r.key_code == KEY_EDIT) begin
          editing   = ~editing;
          edit_item = EDIT_YEAR;
        end
        if (editing) begin
          case (r.key_code)
            KEY_NEXT:  edit_item = (edit_item == EDIT_LAST) ? EDIT_YEAR : edit_item + 3'd1;
            KEY_ADD:   step_time(1'b1);
            KEY_SUB:   step_time(1'b0);
            KEY_STORE: begin
              editing = 1'b0;
              saved   = 1'b1;
            end
            default: ;
          endcase
        end
        if (r.key_code == KEY_ALM_SET) begin
          alarm_editing = ~alarm_editing;
          if (alarm_editing) alarm_edit_min = 1'b0;
        end
        if (r.key_code == KEY_ALM_TOG) begin
          if (ringing_now) begin
            ringing_now = 1'b0;
            silenced    = 1'b1;
            buzzer_pin  = 1'b1;
          end else begin
            alarm_armed = ~alarm_armed;
            silenced    = 1'b0;
          end
        end
        if (alarm_editing) begin
          case (r.key_code)
            KEY_NEXT: alarm_edit_min = ~alarm_edit_min;
            KEY_ALM_UP: begin
              if (!alarm_edit_min)
                alm_hour = (alm_hour >= ALARM_HOUR_MAX) ? 5'd0 : alm_hour + 5'd1;
              else
                alm_minute = (alm_minute >= ALARM_MINUTE_MAX) ? 6'd0 : alm_minute + 6'd1;
            end
            KEY_ALM_DOWN: begin
              if (!alarm_edit_min)
                alm_hour = (alm_hour == 5'd0 || alm_hour > ALARM_HOUR_MAX) ?
                           ALARM_HOUR_MAX : alm_hour - 5'd1;
              else
                alm_minute = (alm_minute == 6'd0 || alm_minute > ALARM_MINUTE_MAX) ?
                             ALARM_MINUTE_MAX : alm_minute - 6'd1;
            end
            default: ;
          endcase
        end
      end
      REQ_TICK: begin
        blink_ticks = blink_ticks + 16'd1;
        if (blink_ticks >= blink_len) begin
          blink_ticks = 16'd0;
          blink_lvl   = ~blink_lvl;
        end
        if (ringing_now) begin
          tone_ticks = tone_ticks + 16'd1;
          if (tone_ticks >= tone_len) begin
            tone_ticks = 16'd0;
            tone_half  = ~tone_half;
          end
          // first half toggles on even counts, second half on every tick
          if (!tone_half) begin
            if (!tone_ticks[0]) buzzer_pin = ~buzzer_pin;
          end else begin
            buzzer_pin = ~buzzer_pin;
          end
        end else begin
          buzzer_pin = 1'b1;
        end
      end
      REQ_LOAD: begin
        // a load is dropped while the time is being edited
        if (!editing) begin
          time_bcd[SLOT_SEC]    = r.load_second;
          time_bcd[SLOT_MINUTE] = r.load_minute;
          time_bcd[SLOT_HOUR]   = r.load_hour;
          time_bcd[SLOT_DAY]    = r.load_day;
          time_bcd[SLOT_MONTH]  = r.load_month;
          time_bcd[SLOT_YEAR]   = r.load_year;
        end
      end
      default: ;
    endcase

    if (alarm_armed && !silenced && !ringing_now &&
        bcd_value(time_bcd[SLOT_HOUR]) == int'(alm_hour) &&
        bcd_value(time_bcd[SLOT_MINUTE]) == int'(alm_minute)) begin
      ringing_now = 1'b1;
      tone_ticks  = 16'd0;
      tone_half   = 1'b0;
    end

    res.out_second       = time_bcd[SLOT_SEC];
    res.out_minute       = time_bcd[SLOT_MINUTE];
    res.out_hour         = time_bcd[SLOT_HOUR];
    res.out_day          = time_bcd[SLOT_DAY];
    res.out_month        = time_bcd[SLOT_MONTH];
    res.out_year         = time_bcd[SLOT_YEAR];
    res.edit_field       = edit_item;
    res.alarm_hour_out   = alm_hour;
    res.alarm_minute_out = alm_minute;
    res.mode_flags       = {blink_lvl, ringing_now, alarm_armed, alarm_edit_min,
                            alarm_editing, editing};
    res.buzzer_level     = buzzer_pin;
    res.write_back       = saved;
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      display_q.delete();
    end else begin
      // results first: a result can never belong to a request taken this edge
      if (out_valid && out_ready) begin
        if (display_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = display_q.pop_front();
          check_field("out_second", want.out_second, out_data.out_second);
          check_field("out_minute", want.out_minute, out_data.out_minute);
          check_field("out_hour", want.out_hour, out_data.out_hour);
          check_field("out_day", want.out_day, out_data.out_day);
          check_field("out_month", want.out_month, out_data.out_month);
          check_field("out_year", want.out_year, out_data.out_year);
          check_field("edit_field", 8'(want.edit_field), 8'(out_data.edit_field));
          check_field("alarm_hour_out", 8'(want.alarm_hour_out),
                      8'(out_data.alarm_hour_out));
          check_field("alarm_minute_out", 8'(want.alarm_minute_out),
                      8'(out_data.alarm_minute_out));
          check_field("mode_flags", 8'(want.mode_flags), 8'(out_data.mode_flags));
          check_field("buzzer_level", 8'(want.buzzer_level), 8'(out_data.buzzer_level));
          check_field("write_back", 8'(want.write_back), 8'(out_data.write_back));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BLINK_PERIOD) blink_len = cfg_data;
        else if (cfg_index == CFG_TONE_SEGMENT) tone_len = cfg_data;
      end
      if (in_valid && in_ready) display_q.push_back(next_display(in_data));
    end
    expected_left = display_q.size();
  end

endmodule

// ----- verif/bcd_clock_setter_with_alarm_tb.sv -----
`timescale 1ns / 1ps

// Top of the alarm clock testbench: clock, reset, request stimulus, result
// back-pressure, register writes, watchdog and verdict. All prediction and
// checking lives in the checker instance.
module bcd_clock_setter_with_alarm_tb;
  import bcdc_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;   // request type with no effect
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_CYCLES    = 400;      // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;     // cycles with no transfer at all
  localparam int DRAIN_CYCLES   = 6;        // extra wait once no result is outstanding

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  req_t        in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_BLINK_PERIOD;
  logic [15:0] cfg_data  = 16'd0;

  int fail_count;
  int expected_left;

  // pacing, in percent per cycle
  int send_idle_pct  = 0;
  int rcv_stall_pct  = 0;

  // long hold-off request: the receiver acts when the toggle changes
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int   items_sent    = 0;
  int   results_seen  = 0;
  int   ring_results  = 0;
  int   saves_seen    = 0;
  int   settings_used = 0;
  int   idle_cycles   = 0;
  rsp_t last_rsp      = '0;

  logic [15:0] blink_set [6] = '{16'd1, 16'd2, 16'd65535, 16'd0, 16'd7, 16'd1000};
  logic [15:0] tone_set  [6] = '{16'd1, 16'd3, 16'd65535, 16'd0, 16'd5, 16'd250};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bcd_clock_setter_with_alarm u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bcd_clock_setter_with_alarm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // Receiver: random stalls, plus the long hold-off counted here
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Result monitor for the summary and for steering the stimulus, plus the
  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        last_rsp <= out_data;
        results_seen++;
        if (out_data.mode_flags[4]) ring_results++;
        if (out_data.write_back) saves_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_left);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] as_bcd(int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // unused fields carry random noise on every request
  function automatic req_t noise_req(logic [1:0] kind);
    req_t r;
    r.req_type    = kind;
    r.key_code    = 4'($urandom_range(15));
    r.load_second = 8'($urandom_range(255));
    r.load_minute = 8'($urandom_range(255));
    r.load_hour   = 8'($urandom_range(255));
    r.load_day    = 8'($urandom_range(255));
    r.load_month  = 8'($urandom_range(255));
    r.load_year   = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic req_t key_req(logic [3:0] k);
    req_t r;
    r          = noise_req(REQ_KEY);
    r.key_code = k;
    return r;
  endfunction

  function automatic req_t load_req(logic [7:0] s, logic [7:0] m, logic [7:0] h,
                                    logic [7:0] d, logic [7:0] mo, logic [7:0] y);
    req_t r;
    r             = noise_req(REQ_LOAD);
    r.load_second = s;
    r.load_minute = m;
    r.load_hour   = h;
    r.load_day    = d;
    r.load_month  = mo;
    r.load_year   = y;
    return r;
  endfunction

  // load that lands on the alarm time as last reported
  function automatic req_t alarm_hit_load();
    return load_req(as_bcd($urandom_range(59)), as_bcd(int'(last_rsp.alarm_minute_out)),
                    as_bcd(int'(last_rsp.alarm_hour_out)), as_bcd($urandom_range(1, 31)),
                    as_bcd($urandom_range(1, 12)), as_bcd($urandom_range(99)));
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      r = noise_req(REQ_TICK);
    end else if (pick < 75) begin
      if ($urandom_range(99) < 85) r = key_req(4'($urandom_range(1, 9)));
      else r = key_req(4'($urandom_range(15)));
    end else if (pick < 93) begin
      if ($urandom_range(1)) begin
        r = noise_req(REQ_LOAD);              // raw bytes, bad digits included
      end else if ($urandom_range(1)) begin
        r = alarm_hit_load();
      end else begin
        r = load_req(as_bcd($urandom_range(59)), as_bcd($urandom_range(59)),
                     as_bcd($urandom_range(23)), as_bcd($urandom_range(1, 31)),
                     as_bcd($urandom_range(1, 12)), as_bcd($urandom_range(99)));
      end
    end else begin
      r = noise_req(REQ_NONE);
    end
    return r;
  endfunction

  // One request transfer, then an optional random idle gap
  task automatic send(req_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Arm the alarm, hit its time and let the melody play for a while
  task automatic alarm_run();
    if (last_rsp.mode_flags[0]) send(key_req(KEY_STORE));
    if (!last_rsp.mode_flags[3]) send(key_req(KEY_ALM_TOG));
    send(alarm_hit_load());
    repeat ($urandom_range(4, 40)) send(noise_req(REQ_TICK));
  endtask

  // Wait until every result is back; the block must be idle for a register write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] blink_v, logic [15:0] tone_v);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BLINK_PERIOD;
    cfg_data  <= blink_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TONE_SEGMENT;
    cfg_data  <= tone_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, wrap in both directions, load ignored while
    // editing, bad BCD digits, alarm edit wraps, ring and stop, no-op requests
    send(noise_req(REQ_NONE));
    send(noise_req(REQ_TICK));
    send(load_req(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
    send(key_req(KEY_EDIT));
    send(key_req(KEY_ADD));                       // year 99 wraps to 0
    send(key_req(KEY_NEXT));
    send(key_req(KEY_ADD));                       // month 12 wraps to 1
    send(load_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));   // dropped
    send(key_req(KEY_STORE));
    send(load_req(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send(key_req(KEY_EDIT));
    send(key_req(KEY_SUB));                       // out-of-range year goes to 99
    send(key_req(KEY_STORE));
    send(key_req(KEY_ALM_SET));
    send(key_req(KEY_ALM_DOWN));                  // hour 0 wraps to 23
    send(key_req(KEY_NEXT));
    send(key_req(KEY_ALM_DOWN));                  // minute 0 wraps to 59
    send(key_req(KEY_ALM_SET));
    send(key_req(KEY_ALM_TOG));                   // enable
    send(load_req(8'h00, 8'h59, 8'h23, 8'h01, 8'h01, 8'h00));   // starts ringing
    send(noise_req(REQ_TICK));
    send(noise_req(REQ_TICK));
    send(key_req(KEY_ALM_TOG));                   // stop
    send(key_req(4'd0));
    send(key_req(4'd15));

    // Random phases over register settings and pacing modes
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_regs(blink_set[ph % 6], tone_set[ph % 6]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; rcv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rcv_stall_pct = 62; end
        default: begin send_idle_pct = 16; rcv_stall_pct = 16; end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        // fill the block against a long receiver hold-off once
        if (ph == 0 && !hold_done && items_sent >= target - PHASE_ITEMS / 2) begin
          hold_req <= ~hold_req;
          hold_done = 1'b1;
        end
        if ($urandom_range(99) < 8) alarm_run();
        else send(random_req());
      end
    end

    drain();
    $display("Checked %0d results from %0d requests over %0d register settings",
             results_seen, items_sent, settings_used);
    $display("%0d results while ringing, %0d saves, four pacing modes and one long hold-off",
             ring_results, saves_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
